// ===== rtl/rmst_pkg.sv =====
// Package for the retry message slot table: types, codes and sizes.
package rmst_pkg;
    localparam int SLOTS = 8;
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        OP_ENQ = 3'd0, OP_SERVICE = 3'd1, OP_LAUNCH = 3'd2,
        OP_DELIVER = 3'd3, OP_FAIL = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0, ST_EVICT = 3'd1, ST_NOTFOUND = 3'd2,
        ST_ABANDON = 3'd3, ST_DEFER = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        SL_FREE = 2'd0, SL_PENDING = 2'd1, SL_SENT = 2'd2, SL_RETRY = 2'd3
    } slot_state_t;

    typedef enum logic [2:0] {
        FSM_IDLE, FSM_SCAN, FSM_SEND, FSM_APPLY, FSM_OUT
    } fsm_t;

    localparam logic CFG_TTL = 1'b0;
    localparam logic CFG_MAXR = 1'b1;
endpackage

// ===== rtl/retry_message_slot_table_core.sv =====
// Slot table top level: sequencer walking the slots one per cycle, pausing for each send request.
// Enqueue, delivered and failed ops walk every slot before the result; launched and
// unknown ops go straight to the result; a service pass walks once when the link is
// not ready (stopping early if it defers), else twice with a send request per waiting slot.
// Throughput: one item at a time; the next is taken once the final result has gone.
// Synchronous active-low reset frees all slots and loads the register defaults.
module retry_message_slot_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_op,
    input  logic [31:0] s_now_ms,
    input  logic [7:0]  s_msg_type,
    input  logic [15:0] s_payload_tag,
    input  logic [15:0] s_msg_id,
    input  logic [2:0]  s_slot_index,
    input  logic        s_link_ready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [2:0]  m_status,
    output logic [2:0]  m_slot_number,
    output logic [7:0]  m_type_out,
    output logic [15:0] m_tag_out,
    output logic [7:0]  m_retries_out,
    output logic [3:0]  m_occupancy,
    output logic [3:0]  m_expired_count,
    output logic        m_last
);
    import rmst_pkg::*;

    // slot storage
    slot_state_t       st_reg [SLOTS];
    logic [7:0]        ty_reg [SLOTS];
    logic [15:0]       tg_reg [SLOTS];
    logic [15:0]       id_reg [SLOTS];
    logic [7:0]        rt_reg [SLOTS];
    logic [31:0]       cr_reg [SLOTS];
    logic [CW-1:0]     occ_reg;
    logic [31:0]       ttl_reg;
    logic [7:0]        maxr_reg;

    // item latch and scan state
    fsm_t              fsm_reg;
    logic [2:0]        op_reg;
    logic [31:0]       now_reg;
    logic [7:0]        mty_reg;
    logic [15:0]       mtg_reg;
    logic [15:0]       mid_reg;
    logic [2:0]        sidx_reg;
    logic              rdy_reg;
    logic [CW-1:0]     i_reg;
    logic              found_reg;
    logic              pass_reg;
    logic [SW-1:0]     sel_reg;
    logic [31:0]       best_reg;
    logic [CW-1:0]     exp_reg;

    // output register
    logic        ov_reg, ok_reg, olast_reg;
    logic [2:0]  ost_reg, oslot_reg;
    logic [7:0]  oty_reg, ort_reg;
    logic [15:0] otg_reg;
    logic [3:0]  oact_reg, oexp_reg;

    logic [SW-1:0] ci;
    logic [31:0]   age;
    logic          at_end;
    assign ci     = i_reg[SW-1:0];
    assign age    = now_reg - cr_reg[ci];
    assign at_end = (i_reg == CW'(SLOTS - 1));

    assign s_ready   = (fsm_reg == FSM_IDLE) && !ov_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = ov_reg;
    assign m_kind = ok_reg;
    assign m_status = ost_reg;
    assign m_slot_number = oslot_reg;
    assign m_type_out = oty_reg;
    assign m_tag_out = otg_reg;
    assign m_retries_out = ort_reg;
    assign m_occupancy = oact_reg;
    assign m_expired_count = oexp_reg;
    assign m_last = olast_reg;

    logic [7:0] rt_inc;
    assign rt_inc = (rt_reg[sel_reg] == 8'hFF) ? 8'hFF : rt_reg[sel_reg] + 8'd1;

    // sequencer: one slot per cycle through the shared compare, pausing for each send request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg  <= FSM_IDLE;
            ov_reg   <= 1'b0;
            occ_reg  <= '0;
            ttl_reg  <= 32'd300000;
            maxr_reg <= 8'd3;
            for (int k = 0; k < SLOTS; k++) st_reg[k] <= SL_FREE;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == CFG_TTL) ttl_reg <= cfg_data;
                else maxr_reg <= cfg_data[7:0];
            end
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            unique case (fsm_reg)
                FSM_IDLE: begin
                    if (s_valid && s_ready) begin
                        op_reg <= s_op; now_reg <= s_now_ms; mty_reg <= s_msg_type;
                        mtg_reg <= s_payload_tag; mid_reg <= s_msg_id;
                        sidx_reg <= s_slot_index; rdy_reg <= s_link_ready;
                        i_reg <= '0; found_reg <= 1'b0; sel_reg <= '0;
                        best_reg <= '0; exp_reg <= '0; pass_reg <= 1'b0;
                        if (s_op == OP_LAUNCH || s_op > OP_FAIL) fsm_reg <= FSM_APPLY;
                        else fsm_reg <= FSM_SCAN;
                    end
                end
                FSM_SCAN: begin
                    fsm_reg <= at_end ? FSM_APPLY : FSM_SCAN;
                    i_reg <= i_reg + 1'b1;
                    case (op_reg)
                        OP_ENQ: begin
                            if (!found_reg && st_reg[ci] == SL_FREE) begin
                                found_reg <= 1'b1; sel_reg <= ci;
                            end
                            if (age > best_reg || i_reg == '0) begin
                                best_reg <= age;
                                if (!found_reg && !(st_reg[ci] == SL_FREE)) sel_reg <= ci;
                            end
                        end
                        OP_SERVICE: begin
                            // first walk drops expired slots, or defers when the link is not ready; second walk sends
                            if (!pass_reg) begin
                                if (st_reg[ci] != SL_FREE) begin
                                    if (age > ttl_reg) begin
                                        st_reg[ci] <= SL_FREE;
                                        occ_reg <= occ_reg - 1'b1;
                                        exp_reg <= exp_reg + 1'b1;
                                    end else if (!rdy_reg &&
                                                 (st_reg[ci] == SL_PENDING ||
                                                  st_reg[ci] == SL_RETRY)) begin
                                        sel_reg <= ci;
                                        found_reg <= 1'b1;
                                        fsm_reg <= FSM_APPLY;
                                    end
                                end
                                if (rdy_reg && at_end) begin
                                    i_reg <= '0;
                                    pass_reg <= 1'b1;
                                    fsm_reg <= FSM_SCAN;
                                end
                            end else if (st_reg[ci] == SL_PENDING ||
                                         st_reg[ci] == SL_RETRY) begin
                                sel_reg <= ci;
                                fsm_reg <= FSM_SEND;
                            end
                        end
                        default: begin
                            if (!found_reg && st_reg[ci] == SL_SENT &&
                                id_reg[ci] == mid_reg) begin
                                found_reg <= 1'b1; sel_reg <= ci;
                            end
                        end
                    endcase
                end
                FSM_SEND: begin
                    if (!ov_reg || m_ready) begin
                        ov_reg <= 1'b1; ok_reg <= 1'b1; ost_reg <= ST_OK;
                        oslot_reg <= 3'(sel_reg); oty_reg <= ty_reg[sel_reg];
                        otg_reg <= tg_reg[sel_reg]; ort_reg <= rt_reg[sel_reg];
                        oact_reg <= 4'(occ_reg); oexp_reg <= '0; olast_reg <= 1'b0;
                        fsm_reg <= (i_reg == CW'(SLOTS)) ? FSM_APPLY : FSM_SCAN;
                    end
                end
                FSM_APPLY: begin
                    if (!ov_reg || m_ready) begin
                        ov_reg <= 1'b1; ok_reg <= 1'b0; olast_reg <= 1'b1;
                        oexp_reg <= '0; oact_reg <= 4'(occ_reg);
                        oslot_reg <= 3'(sel_reg); oty_reg <= ty_reg[sel_reg];
                        otg_reg <= tg_reg[sel_reg]; ort_reg <= rt_reg[sel_reg];
                        fsm_reg <= FSM_IDLE;
                        case (op_reg)
                            OP_ENQ: begin
                                st_reg[sel_reg] <= SL_PENDING;
                                ty_reg[sel_reg] <= mty_reg; tg_reg[sel_reg] <= mtg_reg;
                                rt_reg[sel_reg] <= '0; id_reg[sel_reg] <= '0;
                                cr_reg[sel_reg] <= now_reg;
                                oty_reg <= mty_reg; otg_reg <= mtg_reg; ort_reg <= '0;
                                if (found_reg) begin
                                    ost_reg <= ST_OK;
                                    occ_reg <= occ_reg + 1'b1;
                                    oact_reg <= 4'(occ_reg + 1'b1);
                                end else ost_reg <= ST_EVICT;
                            end
                            OP_SERVICE: begin
                                oexp_reg <= 4'(exp_reg);
                                if (found_reg) ost_reg <= ST_DEFER;
                                else begin
                                    ost_reg <= ST_OK; oslot_reg <= '0;
                                    oty_reg <= '0; otg_reg <= '0; ort_reg <= '0;
                                end
                            end
                            OP_LAUNCH: begin
                                oslot_reg <= sidx_reg;
                                if (CW'(sidx_reg) < CW'(SLOTS) &&
                                    (st_reg[SW'(sidx_reg)] == SL_PENDING ||
                                     st_reg[SW'(sidx_reg)] == SL_RETRY)) begin
                                    st_reg[SW'(sidx_reg)] <= SL_SENT;
                                    id_reg[SW'(sidx_reg)] <= mid_reg;
                                    ost_reg <= ST_OK;
                                    oty_reg <= ty_reg[SW'(sidx_reg)];
                                    otg_reg <= tg_reg[SW'(sidx_reg)];
                                    ort_reg <= rt_reg[SW'(sidx_reg)];
                                end else begin
                                    ost_reg <= ST_NOTFOUND;
                                    oty_reg <= '0; otg_reg <= '0; ort_reg <= '0;
                                end
                            end
                            OP_DELIVER, OP_FAIL: begin
                                if (!found_reg) begin
                                    ost_reg <= ST_NOTFOUND; oslot_reg <= '0;
                                    oty_reg <= '0; otg_reg <= '0; ort_reg <= '0;
                                end else if (op_reg == OP_DELIVER) begin
                                    ost_reg <= ST_OK;
                                    st_reg[sel_reg] <= SL_FREE;
                                    occ_reg <= occ_reg - 1'b1;
                                    oact_reg <= 4'(occ_reg - 1'b1);
                                end else begin
                                    rt_reg[sel_reg] <= rt_inc;
                                    ort_reg <= rt_inc;
                                    if (rt_inc >= maxr_reg) begin
                                        ost_reg <= ST_ABANDON;
                                        st_reg[sel_reg] <= SL_FREE;
                                        occ_reg <= occ_reg - 1'b1;
                                        oact_reg <= 4'(occ_reg - 1'b1);
                                    end else begin
                                        ost_reg <= ST_OK;
                                        st_reg[sel_reg] <= SL_RETRY;
                                    end
                                end
                            end
                            default: begin
                                ost_reg <= ST_NOTFOUND; oslot_reg <= '0;
                                oty_reg <= '0; otg_reg <= '0; ort_reg <= '0;
                            end
                        endcase
                    end
                end
                default: fsm_reg <= FSM_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/rmst_checker.sv =====
// Port-level checker for the slot table, bound to the top level.
module rmst_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_kind,
    input logic       m_last,
    input logic [3:0] m_occupancy,
    input logic [3:0] m_expired_count
);
    // a held result stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    // send requests are never last
    a_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind |-> !m_last) else $error("send marked last");
    // occupancy and expired count bounded
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_occupancy <= 4'd8 && m_expired_count <= 4'd8)
        else $error("count out of range");
    // no new item while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready during result");
endmodule

bind retry_message_slot_table_core rmst_checker u_rmst_checker (.*);

// ===== tb/sv/retry_message_slot_table_core_test.sv =====
// Self-checking testbench for the retry message slot table core.
module retry_message_slot_table_core_test;
    import rmst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 64;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] now_ms;
        logic [7:0]  msg_type;
        logic [15:0] payload_tag;
        logic [15:0] msg_id;
        logic [2:0]  slot_index;
        logic        link_ready;
    } msg_item_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [2:0]  slot_number;
        logic [7:0]  type_out;
        logic [15:0] tag_out;
        logic [7:0]  retries_out;
        logic [3:0]  occupancy;
        logic [3:0]  expired_count;
        logic        last;
    } slot_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_op = '0;
    logic [31:0] s_now_ms = '0;
    logic [7:0]  s_msg_type = '0;
    logic [15:0] s_payload_tag = '0;
    logic [15:0] s_msg_id = '0;
    logic [2:0]  s_slot_index = '0;
    logic        s_link_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [2:0]  m_status;
    logic [2:0]  m_slot_number;
    logic [7:0]  m_type_out;
    logic [15:0] m_tag_out;
    logic [7:0]  m_retries_out;
    logic [3:0]  m_occupancy;
    logic [3:0]  m_expired_count;
    logic        m_last;

    retry_message_slot_table_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state
    logic [31:0]  ttl_reg;
    logic [7:0]   maxr_reg;
    slot_state_t  tbl_state [SLOTS];
    logic [7:0]   tbl_type [SLOTS];
    logic [15:0]  tbl_tag [SLOTS];
    logic [15:0]  tbl_id [SLOTS];
    logic [7:0]   tbl_retries [SLOTS];
    logic [31:0]  tbl_created [SLOTS];
    int           tbl_count;

    msg_item_t    pending_items[$];
    slot_result_t expected_results[$];
    int           mismatches = 0;
    int           results_seen = 0;
    int           items_sent = 0;
    int           idle_cycles = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;
    bit           recv_hold = 1'b0;
    bit           running = 1'b0;
    int           sends_seen = 0;
    int           evicts_seen = 0;
    int           aborts_seen = 0;

    function automatic slot_result_t make_result(logic kind, status_t st, int slot,
                                                 bit show, int expired, logic last);
        slot_result_t r;
        r.kind = kind;
        r.status = st;
        r.slot_number = slot[2:0];
        r.type_out = show ? tbl_type[slot] : 8'd0;
        r.tag_out = show ? tbl_tag[slot] : 16'd0;
        r.retries_out = show ? tbl_retries[slot] : 8'd0;
        r.occupancy = tbl_count[3:0];
        r.expired_count = expired[3:0];
        r.last = last;
        return r;
    endfunction

    // Apply one item to the table copy and queue what the block should emit
    task automatic predict_table_step(msg_item_t it);
        int s, expired, deferred, nsend;
        logic [31:0] best, age;
        status_t st;
        slot_result_t sends[$];
        s = -1;
        st = ST_OK;
        case (it.op)
            OP_ENQ: begin
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && tbl_state[i] == SL_FREE) s = i;
                if (s < 0) begin
                    best = '0;
                    for (int i = 0; i < SLOTS; i++) begin
                        age = it.now_ms - tbl_created[i];
                        if (s < 0 || age > best) begin
                            s = i;
                            best = age;
                        end
                    end
                    st = ST_EVICT;
                end else begin
                    tbl_count++;
                end
                tbl_state[s] = SL_PENDING;
                tbl_type[s] = it.msg_type;
                tbl_tag[s] = it.payload_tag;
                tbl_retries[s] = '0;
                tbl_id[s] = '0;
                tbl_created[s] = it.now_ms;
                expected_results.push_back(make_result(1'b0, st, s, 1, 0, 1'b1));
            end
            OP_SERVICE: begin
                expired = 0;
                deferred = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (deferred >= 0 || tbl_state[i] == SL_FREE) continue;
                    if (it.now_ms - tbl_created[i] > ttl_reg) begin
                        tbl_state[i] = SL_FREE;
                        tbl_count--;
                        expired++;
                    end else if (tbl_state[i] == SL_PENDING || tbl_state[i] == SL_RETRY) begin
                        if (!it.link_ready) deferred = i;
                        else sends.push_back(make_result(1'b1, ST_OK, i, 1, 0, 1'b0));
                    end
                end
                // occupancy in send requests reflects the end of the pass
                nsend = sends.size();
                for (int i = 0; i < nsend; i++) begin
                    sends[i].occupancy = tbl_count[3:0];
                    expected_results.push_back(sends[i]);
                end
                if (deferred >= 0)
                    expected_results.push_back(
                        make_result(1'b0, ST_DEFER, deferred, 1, expired, 1'b1));
                else
                    expected_results.push_back(make_result(1'b0, ST_OK, 0, 0, expired, 1'b1));
            end
            OP_LAUNCH: begin
                s = it.slot_index;
                if (tbl_state[s] == SL_PENDING || tbl_state[s] == SL_RETRY) begin
                    tbl_state[s] = SL_SENT;
                    tbl_id[s] = it.msg_id;
                    expected_results.push_back(make_result(1'b0, ST_OK, s, 1, 0, 1'b1));
                end else begin
                    expected_results.push_back(
                        make_result(1'b0, ST_NOTFOUND, s, 0, 0, 1'b1));
                end
            end
            OP_DELIVER, OP_FAIL: begin
                for (int i = 0; i < SLOTS; i++)
                    if (s < 0 && tbl_state[i] == SL_SENT && tbl_id[i] == it.msg_id) s = i;
                if (s < 0) begin
                    expected_results.push_back(make_result(1'b0, ST_NOTFOUND, 0, 0, 0, 1'b1));
                end else begin
                    if (it.op == OP_DELIVER) begin
                        tbl_state[s] = SL_FREE;
                        tbl_count--;
                    end else begin
                        if (tbl_retries[s] != 8'hFF) tbl_retries[s]++;
                        if (tbl_retries[s] >= maxr_reg) begin
                            tbl_state[s] = SL_FREE;
                            tbl_count--;
                            st = ST_ABANDON;
                        end else begin
                            tbl_state[s] = SL_RETRY;
                        end
                    end
                    expected_results.push_back(make_result(1'b0, st, s, 1, 0, 1'b1));
                end
            end
            default: expected_results.push_back(make_result(1'b0, ST_NOTFOUND, 0, 0, 0, 1'b1));
        endcase
    endtask

    // Driver: offers queued items, idling at random
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_table_step({s_op, s_now_ms, s_msg_type, s_payload_tag,
                                    s_msg_id, s_slot_index, s_link_ready});
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                if (running && pending_items.size() > 0 &&
                    $urandom_range(99, 0) >= send_idle_pct) begin
                    msg_item_t it;
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    {s_op, s_now_ms, s_msg_type, s_payload_tag, s_msg_id,
                     s_slot_index, s_link_ready} <= it;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (aresetn)
            m_ready <= !recv_hold && ($urandom_range(99, 0) >= recv_stall_pct);
    end

    // Monitor: compare each result with the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            slot_result_t got, exp_r;
            got = {m_kind, m_status, m_slot_number, m_type_out, m_tag_out,
                   m_retries_out, m_occupancy, m_expired_count, m_last};
            results_seen++;
            if (got.kind) sends_seen++;
            if (!got.kind && got.status == ST_EVICT) evicts_seen++;
            if (!got.kind && got.status == ST_ABANDON) aborts_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, got);
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired");
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic msg_item_t make_item(op_t op, logic [31:0] now, logic [15:0] id,
                                            logic [2:0] sidx, logic rdy);
        msg_item_t it;
        it.op = op;
        it.now_ms = now;
        it.msg_type = 8'($urandom);
        it.payload_tag = 16'($urandom);
        it.msg_id = id;
        it.slot_index = sidx;
        it.link_ready = rdy;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(logic idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_TTL) ttl_reg = val;
        else maxr_reg = val[7:0];
    endtask

    // Random flow: mostly coherent launch/deliver/fail on known slots
    task automatic queue_random(int n, ref logic [31:0] clock_ms);
        int r;
        for (int k = 0; k < n; k++) begin
            clock_ms += $urandom_range(2000, 0);
            r = $urandom_range(99, 0);
            if (r < 30)
                pending_items.push_back(make_item(OP_ENQ, clock_ms, 16'($urandom),
                                                  3'($urandom), 1'b1));
            else if (r < 50)
                pending_items.push_back(make_item(OP_SERVICE, clock_ms, 16'($urandom),
                                                  3'($urandom),
                                                  $urandom_range(9, 0) != 0));
            else if (r < 70)
                pending_items.push_back(make_item(OP_LAUNCH, clock_ms,
                                                  16'($urandom_range(7, 0)),
                                                  3'($urandom), 1'b1));
            else if (r < 80)
                pending_items.push_back(make_item(OP_DELIVER, clock_ms,
                                                  16'($urandom_range(7, 0)),
                                                  3'($urandom), 1'b1));
            else if (r < 95)
                pending_items.push_back(make_item(OP_FAIL, clock_ms,
                                                  16'($urandom_range(7, 0)),
                                                  3'($urandom), 1'b1));
            else
                pending_items.push_back(make_item(op_t'($urandom_range(7, 0)), $urandom,
                                                  16'($urandom), 3'($urandom),
                                                  1'($urandom)));
        end
    endtask

    initial begin
        logic [31:0] clock_ms;
        msg_item_t it;
        ttl_reg = 32'd300000;
        maxr_reg = 8'd3;
        tbl_count = 0;
        for (int i = 0; i < SLOTS; i++) begin
            tbl_state[i] = SL_FREE;
            tbl_type[i] = '0;
            tbl_tag[i] = '0;
            tbl_id[i] = '0;
            tbl_retries[i] = '0;
            tbl_created[i] = '0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: fill past capacity near the time wrap, evict, serve, fail and retry, expire
        clock_ms = 32'hFFFF_FFF0;
        for (int i = 0; i < 9; i++) begin
            it = make_item(OP_ENQ, clock_ms + 32'(i * 4), 16'hFFFF, 3'd7, 1'b1);
            it.msg_type = (i == 0) ? 8'hFF : 8'h00;
            it.payload_tag = (i == 1) ? 16'hFFFF : 16'h0000;
            pending_items.push_back(it);
        end
        pending_items.push_back(make_item(OP_SERVICE, clock_ms + 32'd40, 16'd0, 3'd0, 1'b0));
        pending_items.push_back(make_item(OP_SERVICE, clock_ms + 32'd40, 16'd0, 3'd0, 1'b1));
        pending_items.push_back(make_item(OP_LAUNCH, clock_ms, 16'hFFFF, 3'd7, 1'b1));
        pending_items.push_back(make_item(OP_LAUNCH, clock_ms, 16'h0000, 3'd0, 1'b1));
        pending_items.push_back(make_item(OP_LAUNCH, clock_ms, 16'h0000, 3'd0, 1'b1));
        pending_items.push_back(make_item(OP_FAIL, clock_ms, 16'hFFFF, 3'd0, 1'b1));
        pending_items.push_back(make_item(OP_LAUNCH, clock_ms, 16'hFFFF, 3'd7, 1'b1));
        pending_items.push_back(make_item(OP_FAIL, clock_ms, 16'hFFFF, 3'd0, 1'b1));
        pending_items.push_back(make_item(OP_DELIVER, clock_ms, 16'h0000, 3'd0, 1'b1));
        pending_items.push_back(make_item(OP_DELIVER, clock_ms, 16'h1234, 3'd0, 1'b1));
        pending_items.push_back(make_item(op_t'(3'd5), 32'hFFFF_FFFF, 16'd0, 3'd0, 1'b0));
        pending_items.push_back(make_item(op_t'(3'd7), 32'd0, 16'd0, 3'd0, 1'b1));
        pending_items.push_back(make_item(OP_SERVICE, clock_ms + 32'd400000, 16'd0, 3'd0,
                                          1'b1));
        running = 1'b1;
        wait_drained();

        // Random phases over several register settings
        clock_ms = $urandom;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_register(CFG_TTL, 32'd0);          write_register(CFG_MAXR, 32'd1); end
                1: begin write_register(CFG_TTL, 32'hFFFF_FFFF); write_register(CFG_MAXR, 32'd255); end
                2: begin write_register(CFG_TTL, 32'd6000);       write_register(CFG_MAXR, 32'd2); end
                3: begin write_register(CFG_TTL, $urandom_range(20000, 1000));
                         write_register(CFG_MAXR, $urandom_range(5, 1)); end
                default: begin write_register(CFG_TTL, 32'd300000); write_register(CFG_MAXR, 32'd3); end
            endcase
            send_idle_pct = (ph == 1 || ph == 4) ? 79 : (ph == 3 ? 14 : 0);
            recv_stall_pct = (ph == 2 || ph == 4) ? 79 : (ph == 3 ? 14 : 0);
            if (ph == 2) recv_hold = 1'b1;
            queue_random(26, clock_ms);
            if (ph == 2) begin
                repeat (300) @(posedge aclk);
                recv_hold = 1'b0;
            end
            wait_drained();
        end

        $display("ran %0d items, %0d results: %0d send requests, %0d evictions, %0d abandons",
                 items_sent, results_seen, sends_seen, evicts_seen, aborts_seen);
        $display("register settings covered ttl 0, max and mid values, retry limit 1 to 255");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// ===== retry_message_slot_table_core.f =====
rtl/rmst_pkg.sv
rtl/retry_message_slot_table_core.sv
rtl/rmst_checker.sv
tb/sv/retry_message_slot_table_core_test.sv
